FILE: hw/rtl/aavr_pkg.sv
// ----------------------------------------------------------------------------
// aavr_pkg
// Shared types, constants and helpers for the axis-angle vector rotator.
// ----------------------------------------------------------------------------
package aavr_pkg;

  // CORDIC iteration count, 8 to 24
  localparam int TRIG_STEPS   = 16;
  localparam int ATAN_ENTRIES = 24;

  // beat widths
  localparam int S_TDATA_W = 112;
  localparam int M_TDATA_W = 48;

  // CORDIC datapath: Q2.30 for x/y, 2^-32 turn units for z
  localparam int CW = 34;
  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [15:0]   v16_t;

  localparam cw_t CORDIC_X0    = 34'sd652032874;
  localparam cw_t QUARTER_TURN = 34'sd1073741824;
  localparam cw_t HALF_TURN    = 34'sh080000000;

  localparam cw_t ATAN_TURNS [ATAN_ENTRIES] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81
  };

  // product / sum widths
  localparam int CRW = 33;  // cross product component
  localparam int DW  = 34;  // dot product
  localparam int OMW = 17;  // 1 - cos, Q2.14, 0..2.0
  localparam int T2W = CRW + 16;
  localparam int DOW = DW + OMW;
  localparam int DLO = 25;  // low slice of dot*omc for the split multiply
  localparam int T3W = 16 + (DOW - DLO);
  localparam int SW  = 64;
  localparam int RW  = SW - 42;

  typedef logic signed [31:0]    prod_t;
  typedef logic signed [CRW-1:0] cr_t;
  typedef logic signed [DW-1:0]  dot_t;
  typedef logic signed [OMW-1:0] omc_t;
  typedef logic signed [T2W-1:0] t2_t;
  typedef logic signed [DOW-1:0] dom_t;
  typedef logic signed [T3W-1:0] t3_t;
  typedef logic signed [SW-1:0]  sum_t;
  typedef logic signed [RW-1:0]  rnd_t;

  // Q2.30 -> Q1.14, round half up, clamp to +-1.0
  function automatic v16_t trig_round(cw_t v);
    cw_t r;
    v16_t o;
    r = (v + cw_t'(32768)) >>> 16;
    if (r > cw_t'(16384)) begin
      o = 16'sd16384;
    end else if (r < -cw_t'(16384)) begin
      o = -16'sd16384;
    end else begin
      o = r[15:0];
    end
    return o;
  endfunction

endpackage

FILE: hw/rtl/axis_angle_vector_rotate_unit.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate_unit
// Throughput: one beat per cycle while the output does not stall; set by the
// unrolled CORDIC, one stage per iteration, followed by a six-stage multiply
// and sum pipeline.
// Stalls back up only through full stages; bubbles are squeezed out.
// Reset clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotate_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle
  input  logic [aavr_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // rot_x, rot_y, rot_z
  output logic [aavr_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // clipped
  output logic                          m_axis_tuser_o
);
  import aavr_pkg::*;

  localparam int S_P1  = TRIG_STEPS + 1;
  localparam int S_P2  = TRIG_STEPS + 2;
  localparam int S_P3  = TRIG_STEPS + 3;
  localparam int S_P4  = TRIG_STEPS + 4;
  localparam int S_P5  = TRIG_STEPS + 5;
  localparam int S_OUT = TRIG_STEPS + 6;
  localparam int NS    = TRIG_STEPS + 7;
  localparam logic [NS-1:0] ONES = '1;

  // ---------------- stage control ----------------
  logic [NS-1:0] valid_q;
  logic [NS-1:0] adv;

  // a stage may load when the output drains or any stage at or after it is empty
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      adv[k] = m_axis_tready_i | (|(~valid_q & (ONES << k)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) begin
          valid_q[k] <= (k == 0) ? s_axis_tvalid_i : valid_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign s_axis_tready_o = adv[0];
  assign m_axis_tvalid_o = valid_q[S_OUT];

  // ---------------- input decode and angle reduction ----------------
  v16_t in_vec  [3];
  v16_t in_axis [3];
  cw_t  z_raw, z_red;
  logic flip_in;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_vec[k]  = s_axis_tdata_i[16*k +: 16];
      in_axis[k] = s_axis_tdata_i[48 + 16*k +: 16];
    end
    z_raw   = CW'($signed({s_axis_tdata_i[111:96], 16'h0000}));
    z_red   = z_raw;
    flip_in = 1'b0;
    if (z_raw > QUARTER_TURN) begin
      z_red   = z_raw - HALF_TURN;
      flip_in = 1'b1;
    end else if (z_raw < -QUARTER_TURN) begin
      z_red   = z_raw + HALF_TURN;
      flip_in = 1'b1;
    end
  end

  // ---------------- CORDIC pipeline ----------------
  cw_t  cx_q   [TRIG_STEPS+1];
  cw_t  cy_q   [TRIG_STEPS+1];
  cw_t  cz_q   [TRIG_STEPS];
  logic flip_q [TRIG_STEPS+1];
  v16_t vec_q  [TRIG_STEPS+1][3];
  v16_t axis_q [TRIG_STEPS+1][3];

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      cx_q[0]   <= CORDIC_X0;
      cy_q[0]   <= '0;
      cz_q[0]   <= z_red;
      flip_q[0] <= flip_in;
      vec_q[0]  <= in_vec;
      axis_q[0] <= in_axis;
    end
  end

  for (genvar i = 0; i < TRIG_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (adv[i+1]) begin
        if (!cz_q[i][CW-1]) begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
        end else begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
        end
        flip_q[i+1] <= flip_q[i];
        vec_q[i+1]  <= vec_q[i];
        axis_q[i+1] <= axis_q[i];
      end
    end
    if (i < TRIG_STEPS - 1) begin : g_z
      always_ff @(posedge clk_i) begin
        if (adv[i+1]) begin
          cz_q[i+1] <= cz_q[i][CW-1] ? cz_q[i] + ATAN_TURNS[i] : cz_q[i] - ATAN_TURNS[i];
        end
      end
    end
  end

  // ---------------- P1: round trig, pairwise products ----------------
  v16_t  c_rnd, s_rnd;
  v16_t  p1_c_q, p1_s_q;
  prod_t p1_m_q [9];
  v16_t  p1_v_q [3];
  v16_t  p1_a_q [3];

  always_comb begin
    c_rnd = trig_round(cx_q[TRIG_STEPS]);
    s_rnd = trig_round(cy_q[TRIG_STEPS]);
    if (flip_q[TRIG_STEPS]) begin
      c_rnd = -c_rnd;
      s_rnd = -s_rnd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_P1]) begin
      p1_c_q    <= c_rnd;
      p1_s_q    <= s_rnd;
      // cross product terms
      p1_m_q[0] <= axis_q[TRIG_STEPS][1] * vec_q[TRIG_STEPS][2];
      p1_m_q[1] <= axis_q[TRIG_STEPS][2] * vec_q[TRIG_STEPS][1];
      p1_m_q[2] <= axis_q[TRIG_STEPS][2] * vec_q[TRIG_STEPS][0];
      p1_m_q[3] <= axis_q[TRIG_STEPS][0] * vec_q[TRIG_STEPS][2];
      p1_m_q[4] <= axis_q[TRIG_STEPS][0] * vec_q[TRIG_STEPS][1];
      p1_m_q[5] <= axis_q[TRIG_STEPS][1] * vec_q[TRIG_STEPS][0];
      // dot product terms
      p1_m_q[6] <= axis_q[TRIG_STEPS][0] * vec_q[TRIG_STEPS][0];
      p1_m_q[7] <= axis_q[TRIG_STEPS][1] * vec_q[TRIG_STEPS][1];
      p1_m_q[8] <= axis_q[TRIG_STEPS][2] * vec_q[TRIG_STEPS][2];
      p1_v_q    <= vec_q[TRIG_STEPS];
      p1_a_q    <= axis_q[TRIG_STEPS];
    end
  end

  // ---------------- P2: cross, dot, 1 - cos ----------------
  cr_t  p2_cr_q [3];
  dot_t p2_dot_q;
  omc_t p2_omc_q;
  v16_t p2_c_q, p2_s_q;
  v16_t p2_v_q [3];
  v16_t p2_a_q [3];

  always_ff @(posedge clk_i) begin
    if (adv[S_P2]) begin
      for (int k = 0; k < 3; k++) begin
        p2_cr_q[k] <= CRW'(p1_m_q[2*k]) - CRW'(p1_m_q[2*k+1]);
      end
      p2_dot_q <= DW'(p1_m_q[6]) + DW'(p1_m_q[7]) + DW'(p1_m_q[8]);
      p2_omc_q <= 17'sd16384 - OMW'(p1_c_q);
      p2_c_q   <= p1_c_q;
      p2_s_q   <= p1_s_q;
      p2_v_q   <= p1_v_q;
      p2_a_q   <= p1_a_q;
    end
  end

  // ---------------- P3: first multiply level ----------------
  prod_t p3_t1_q [3];
  t2_t   p3_t2_q [3];
  dom_t  p3_dom_q;
  v16_t  p3_a_q [3];

  always_ff @(posedge clk_i) begin
    if (adv[S_P3]) begin
      for (int k = 0; k < 3; k++) begin
        p3_t1_q[k] <= p2_v_q[k] * p2_c_q;
        p3_t2_q[k] <= p2_cr_q[k] * p2_s_q;
      end
      p3_dom_q <= p2_dot_q * p2_omc_q;
      p3_a_q   <= p2_a_q;
    end
  end

  // ---------------- P4: axis times (dot * omc), split in two halves ----------
  logic signed [DOW-DLO-1:0] dom_hi;
  logic signed [DLO:0]       dom_lo;
  prod_t p4_t1_q [3];
  t2_t   p4_t2_q [3];
  t3_t   p4_t3h_q [3];
  t3_t   p4_t3l_q [3];

  assign dom_hi = p3_dom_q[DOW-1:DLO];
  assign dom_lo = $signed({1'b0, p3_dom_q[DLO-1:0]});

  always_ff @(posedge clk_i) begin
    if (adv[S_P4]) begin
      for (int k = 0; k < 3; k++) begin
        p4_t3h_q[k] <= p3_a_q[k] * dom_hi;
        p4_t3l_q[k] <= p3_a_q[k] * dom_lo;
      end
      p4_t1_q <= p3_t1_q;
      p4_t2_q <= p3_t2_q;
    end
  end

  // ---------------- P5: align terms to Q54 ----------------
  sum_t p5_t12_q [3];
  sum_t p5_t3_q  [3];

  always_ff @(posedge clk_i) begin
    if (adv[S_P5]) begin
      for (int k = 0; k < 3; k++) begin
        p5_t12_q[k] <= (SW'(p4_t1_q[k]) <<< 28) + (SW'(p4_t2_q[k]) <<< 14);
        p5_t3_q[k]  <= (SW'(p4_t3h_q[k]) <<< DLO) + SW'(p4_t3l_q[k]);
      end
    end
  end

  // ---------------- output: sum, round to Q4.12, saturate ----------------
  sum_t sum_w [3];
  rnd_t rnd_w [3];
  v16_t rot_d [3];
  logic clip_d;
  v16_t rot_q [3];
  logic clip_q;

  always_comb begin
    clip_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      sum_w[k] = p5_t12_q[k] + p5_t3_q[k] + (sum_t'(1) <<< 41);
      rnd_w[k] = RW'(sum_w[k] >>> 42);
      if (rnd_w[k] > rnd_t'(32767)) begin
        rot_d[k] = 16'sh7fff;
        clip_d   = 1'b1;
      end else if (rnd_w[k] < -rnd_t'(32768)) begin
        rot_d[k] = 16'sh8000;
        clip_d   = 1'b1;
      end else begin
        rot_d[k] = rnd_w[k][15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_OUT]) begin
      rot_q  <= rot_d;
      clip_q <= clip_d;
    end
  end

  assign m_axis_tdata_o = {rot_q[2], rot_q[1], rot_q[0]};
  assign m_axis_tuser_o = clip_q;

  // ---------------- checks ----------------
  a_drain_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while output drains");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&valid_q) && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("beat accepted into a full stalled pipeline");

  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[S_P1] |-> (p1_c_q <= 16'sd16384 && p1_c_q >= -16'sd16384 &&
                       p1_s_q <= 16'sd16384 && p1_s_q >= -16'sd16384))
    else $error("sine or cosine out of range");

  a_omc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[S_P2] |-> (p2_omc_q >= 17'sd0 && p2_omc_q <= 17'sd32768))
    else $error("one minus cosine out of range");

endmodule

FILE: verif/aavr_rotation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aavr_rotation_checker
// Watches both stream ports of the rotator, computes the rotated vector for
// every input beat with a bit-exact Rodrigues/CORDIC model and compares each
// output beat in order against it.
// ----------------------------------------------------------------------------
module aavr_rotation_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle
  input  logic [aavr_pkg::S_TDATA_W-1:0] s_tdata_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  // rot_x, rot_y, rot_z
  input  logic [aavr_pkg::M_TDATA_W-1:0] m_tdata_i,
  // clipped
  input  logic                           m_tuser_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o,
  output int                             clipped_o
);

  import aavr_pkg::*;

  localparam longint GAIN_Q30     = 64'sd652032874;
  localparam longint QUARTER_REV  = 64'sd1073741824;
  localparam longint HALF_REV     = 64'sd2147483648;
  localparam int     ATAN_COUNT   = 24;
  localparam int     REPORT_LIMIT = 10;

  typedef struct packed {
    logic        clipped;
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
  } rot_vec_t;

  rot_vec_t rotated_q[$];
  rot_vec_t want;
  rot_vec_t got;

  // arctan(2^-i) in units of 2^-32 turn
  function automatic longint atan_rev(input int i);
    case (i)
      0:  return 536870912;
      1:  return 316933406;
      2:  return 167458907;
      3:  return 85004756;
      4:  return 42667331;
      5:  return 21354465;
      6:  return 10679838;
      7:  return 5340245;
      8:  return 2670163;
      9:  return 1335087;
      10: return 667544;
      11: return 333772;
      12: return 166886;
      13: return 83443;
      14: return 41722;
      15: return 20861;
      16: return 10430;
      17: return 5215;
      18: return 2608;
      19: return 1304;
      20: return 652;
      21: return 326;
      22: return 163;
      default: return 81;
    endcase
  endfunction

  function automatic void cordic_sin_cos(input logic [15:0] turn,
                                         output longint cos_q14,
                                         output longint sin_q14);
    longint z, x, y, dx, dy;
    bit     flip;
    int     i;
    z    = longint'(turn) << 16;
    x    = GAIN_Q30;
    y    = 0;
    flip = 1'b0;
    if (z >= HALF_REV) z -= 2 * HALF_REV;
    // fold into +-quarter turn, undo with a sign flip afterwards
    if (z > QUARTER_REV) begin
      z -= HALF_REV;
      flip = 1'b1;
    end else if (z < -QUARTER_REV) begin
      z += HALF_REV;
      flip = 1'b1;
    end
    for (i = 0; i < TRIG_STEPS && i < ATAN_COUNT; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_rev(i);
      end else begin
        x += dx;
        y -= dy;
        z += atan_rev(i);
      end
    end
    x = (x + 32768) >>> 16;
    y = (y + 32768) >>> 16;
    if (x > 16384) x = 16384;
    if (x < -16384) x = -16384;
    if (y > 16384) y = 16384;
    if (y < -16384) y = -16384;
    cos_q14 = flip ? -x : x;
    sin_q14 = flip ? -y : y;
  endfunction

  function automatic rot_vec_t rotate_about_axis(input logic [S_TDATA_W-1:0] d);
    longint   v[3];
    longint   a[3];
    longint   cr[3];
    longint   c, s, omc, dot, t1, t2, t3, r;
    rot_vec_t o;
    int       k;
    for (k = 0; k < 3; k++) begin
      v[k] = longint'($signed(d[16*k +: 16]));
      a[k] = longint'($signed(d[48 + 16*k +: 16]));
    end
    cordic_sin_cos(d[111:96], c, s);
    omc   = 16384 - c;
    cr[0] = a[1] * v[2] - a[2] * v[1];
    cr[1] = a[2] * v[0] - a[0] * v[2];
    cr[2] = a[0] * v[1] - a[1] * v[0];
    dot   = a[0] * v[0] + a[1] * v[1] + a[2] * v[2];
    o.clipped = 1'b0;
    for (k = 0; k < 3; k++) begin
      // all three terms aligned to Q54, one rounding to Q4.12
      t1 = v[k] * c * 64'sd268435456;
      t2 = cr[k] * s * 64'sd16384;
      t3 = a[k] * dot * omc;
      r  = (t1 + t2 + t3 + (64'sd1 <<< 41)) >>> 42;
      if (r > 32767) begin
        r = 32767;
        o.clipped = 1'b1;
      end else if (r < -32768) begin
        r = -32768;
        o.clipped = 1'b1;
      end
      case (k)
        0:       o.x = r[15:0];
        1:       o.y = r[15:0];
        default: o.z = r[15:0];
      endcase
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotated_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      clipped_o    <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = {m_tuser_i, m_tdata_i[47:32], m_tdata_i[31:16], m_tdata_i[15:0]};
        if (rotated_q.size() == 0) begin
          if (fail_count_o < REPORT_LIMIT)
            $display("%0t: output beat with nothing outstanding: x=%0d y=%0d z=%0d clip=%0b",
                     $realtime, $signed(got.x), $signed(got.y), $signed(got.z), got.clipped);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = rotated_q.pop_front();
          if (got !== want) begin
            if (fail_count_o < REPORT_LIMIT)
              $display("%0t: beat %0d mismatch: want x=%0d y=%0d z=%0d clip=%0b, got x=%0d y=%0d z=%0d clip=%0b",
                       $realtime, checked_o,
                       $signed(want.x), $signed(want.y), $signed(want.z), want.clipped,
                       $signed(got.x), $signed(got.y), $signed(got.z), got.clipped);
            fail_count_o <= fail_count_o + 1;
          end
          if (want.clipped) clipped_o <= clipped_o + 1;
        end
        checked_o <= checked_o + 1;
      end
      if (s_tvalid_i && s_tready_i) rotated_q.push_back(rotate_about_axis(s_tdata_i));
      pending_o <= rotated_q.size();
    end
  end

endmodule

FILE: verif/axis_angle_vector_rotate_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate_unit_test
// Feeds the axis-angle rotator a directed set of corner beats, then random
// rotations (mostly unit axes, some raw and edge-valued fields) with random
// gaps and backpressure; the checker module does the scoring.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotate_unit_test;

  import aavr_pkg::*;

  localparam int RANDOM_BEATS   = 1200;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = TRIG_STEPS + 6 + 16;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic                 m_axis_tuser_o;

  int fail_count;
  int pending;
  int checked;
  int clipped_seen;
  int directed_sent;
  int random_sent;
  int tx_left;
  bit tx_eager;

  axis_angle_vector_rotate_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  aavr_rotation_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_i   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_i    (m_axis_tdata_o),
    .m_tuser_i    (m_axis_tuser_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .clipped_o    (clipped_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [S_TDATA_W-1:0] pack_beat(
    input logic [15:0] vx, input logic [15:0] vy, input logic [15:0] vz,
    input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az,
    input logic [15:0] angle);
    return {angle, az, ay, ax, vz, vy, vx};
  endfunction

  // near-unit axis in Q1.14, packed {z, y, x}
  function automatic logic [47:0] unit_axis();
    int  rx, ry, rz;
    real n;
    do begin
      rx = int'($urandom_range(0, 2000)) - 1000;
      ry = int'($urandom_range(0, 2000)) - 1000;
      rz = int'($urandom_range(0, 2000)) - 1000;
    end while (rx == 0 && ry == 0 && rz == 0);
    n = $sqrt(real'(rx * rx + ry * ry + rz * rz));
    return {16'($rtoi(16384.0 * rz / n)), 16'($rtoi(16384.0 * ry / n)),
            16'($rtoi(16384.0 * rx / n))};
  endfunction

  function automatic logic [15:0] edge_value();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      4:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // angles around the quadrant folds
  function automatic logic [15:0] edge_angle();
    case ($urandom_range(0, 11))
      0:       return 16'h0000;
      1:       return 16'h3FFF;
      2:       return 16'h4000;
      3:       return 16'h4001;
      4:       return 16'h7FFF;
      5:       return 16'h8000;
      6:       return 16'h8001;
      7:       return 16'hBFFF;
      8:       return 16'hC000;
      9:       return 16'hC001;
      10:      return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] moderate();
    return 16'(int'($urandom_range(0, 32767)) - 16384);
  endfunction

  task automatic send_beat(input logic [S_TDATA_W-1:0] d);
    int gap;
    if (tx_left == 0) begin
      tx_eager = ($urandom_range(0, 3) == 0);
      tx_left  = $urandom_range(20, 80);
    end
    tx_left--;
    gap = tx_eager ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i  = d;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic send_directed();
    logic [47:0] ax;
    ax = unit_axis();
    // plain rotations about z through each quadrant
    send_beat(pack_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000));
    send_beat(pack_beat(16'd4096, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000));
    send_beat(pack_beat(16'd4096, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h4000));
    send_beat(pack_beat(16'd4096, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h8000));
    send_beat(pack_beat(16'd4096, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'hC000));
    send_beat(pack_beat(16'd4096, 16'd2048, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'hFFFF));
    send_beat(pack_beat(16'd4096, 16'd2048, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0001));
    // fold boundaries just past a quarter turn either way
    send_beat(pack_beat(16'd4096, 16'd4096, 16'd4096, 16'h0000, 16'h0000, 16'h4000, 16'h4001));
    send_beat(pack_beat(16'd4096, 16'd4096, 16'd4096, 16'h0000, 16'h0000, 16'h4000, 16'hBFFF));
    // other axes
    send_beat(pack_beat(16'h0000, 16'd4096, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h2000));
    send_beat(pack_beat(16'h0000, 16'h0000, 16'd4096, 16'h0000, 16'h4000, 16'h0000, 16'hE000));
    send_beat(pack_beat(16'd4096, 16'd4096, 16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h6000));
    // field extremes, saturation
    send_beat(pack_beat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h4000, 16'h0000, 16'h0000, 16'h8000));
    send_beat(pack_beat(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h4000, 16'h2000));
    send_beat(pack_beat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'h0000, 16'h1000));
    // axes far from unit length, then one random unit axis
    send_beat(pack_beat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000));
    send_beat(pack_beat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h4000));
    send_beat(pack_beat(16'h1234, 16'hEDCB, 16'h0F0F, 16'h0000, 16'h0000, 16'h0000, 16'h1234));
    send_beat(pack_beat(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFF));
    send_beat(pack_beat(16'h0100, 16'h0200, 16'h0300, 16'h2000, 16'h2000, 16'h2000, 16'h5555));
    send_beat(pack_beat(16'hF000, 16'h0800, 16'h7000, ax[15:0], ax[31:16], ax[47:32], 16'hAAAA));
    directed_sent = 21;
  endtask

  task automatic send_random();
    logic [47:0] ax;
    int          kind;
    int          n;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      kind = $urandom_range(0, 9);
      ax   = unit_axis();
      if (kind <= 5) begin
        send_beat(pack_beat(moderate(), moderate(), moderate(),
                            ax[15:0], ax[31:16], ax[47:32], 16'($urandom)));
      end else if (kind <= 7) begin
        send_beat(pack_beat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom)));
      end else if (kind == 8) begin
        send_beat(pack_beat(edge_value(), edge_value(), edge_value(), edge_value(),
                            edge_value(), edge_value(), edge_angle()));
      end else begin
        send_beat(pack_beat(16'($urandom), 16'($urandom), 16'($urandom),
                            ax[15:0], ax[31:16], ax[47:32], edge_angle()));
      end
      random_sent++;
    end
  endtask

  // output side backpressure
  initial begin : rx_side
    int gap;
    int left_in_mode;
    bit eager;
    m_axis_tready_i = 1'b0;
    left_in_mode    = 0;
    eager           = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (left_in_mode == 0) begin
        eager        = ($urandom_range(0, 3) == 0);
        left_in_mode = $urandom_range(20, 80);
      end
      left_in_mode--;
      gap = eager ? 0 : $urandom_range(0, 14);
      @(negedge clk_i);
      if (gap > 0) begin
        m_axis_tready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle = 0;
      else
        idle++;
    end
    $display("no beat moved for %0d cycles, %0d results outstanding", idle, pending);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int fails;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    directed_sent   = 0;
    random_sent     = 0;
    tx_left         = 0;
    tx_eager        = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_directed();
    send_random();
    s_axis_tvalid_i = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    fails = fail_count + pending;
    if (pending != 0) $display("%0d expected results never arrived", pending);
    $display("sent %0d corner-case and %0d random rotations; %0d results compared",
             directed_sent, random_sent, checked);
    $display("%0d results saturated, %0d mismatches", clipped_seen, fail_count);
    if (fails == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/aavr_pkg.sv
hw/rtl/axis_angle_vector_rotate_unit.sv
verif/aavr_rotation_checker.sv
verif/axis_angle_vector_rotate_unit_test.sv
